// ===== hdl/json_structure_emitter_core_macros.svh =====
// ----------------------------------------------------------------------------
// json_structure_emitter_core assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRUCTURE_EMITTER_CORE_MACROS_SVH
`define JSON_STRUCTURE_EMITTER_CORE_MACROS_SVH

// same-cycle implication
`define JSE_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JSE_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Constants, codes and control/status types of the JSON structure emitter.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int MAX_DEPTH  = 8;
   localparam int COUNT_BITS = 16;
   localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int TOTAL_W    = COUNT_BITS + 1;

   localparam int BIN_W      = 32;
   localparam int DIGITS     = 10;
   localparam int DIG_W      = $clog2(DIGITS);
   localparam int STEP_W     = $clog2(BIN_W + 1);

   localparam logic [2:0] CMD_OPEN_ARRAY  = 3'd0;
   localparam logic [2:0] CMD_OPEN_OBJECT = 3'd1;
   localparam logic [2:0] CMD_INTEGER     = 3'd2;
   localparam logic [2:0] CMD_STR_BYTE    = 3'd3;
   localparam logic [2:0] CMD_EMPTY_STR   = 3'd4;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_LAYER = 2'd1;
   localparam logic [1:0] ERR_TOO_DEEP = 2'd2;

   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NUL      = 8'h00;

   typedef enum logic [3:0] {
      SEL_OPEN,
      SEL_CLOSE,
      SEL_SEP,
      SEL_QUOTE,
      SEL_MINUS,
      SEL_DIGIT,
      SEL_STR,
      SEL_ERR_LAYER,
      SEL_ERR_DEEP
   } sel_type;

   typedef struct packed {
      logic    latch;
      logic    emit;
      sel_type sel;
      logic    last;
      logic    push;
      logic    after_step;
      logic    set_instr;
      logic    clr_instr;
      logic    conv_start;
      logic    dig_next;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       cnt_zero;
      logic       str_last;
      logic       depth_zero;
      logic       depth_one;
      logic       depth_full;
      logic       in_string;
      logic       neg;
      logic       conv_busy;
      logic       top_more;
      logic       dig_zero;
      logic       dig_last;
      logic       started;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== hdl/jse_bcd.sv =====
// ----------------------------------------------------------------------------
// jse_bcd
// Binary to decimal converter, shift-and-add-3, one input bit per cycle.
// ----------------------------------------------------------------------------
module jse_bcd (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [jse_pkg::BIN_W-1:0]             bin,
   output logic                                  busy,
   output logic [jse_pkg::DIGITS-1:0][3:0]       digits
);

   localparam int BCD_W = jse_pkg::DIGITS * 4;

   logic [jse_pkg::BIN_W-1:0]          bin_ff;
   logic [jse_pkg::DIGITS-1:0][3:0]    bcd_ff;
   logic [jse_pkg::DIGITS-1:0][3:0]    adj;
   logic [BCD_W-1:0]                   adj_flat;
   logic [BCD_W-1:0]                   bcd_in;
   logic [jse_pkg::STEP_W-1:0]         cnt_ff;
   logic                               busy_ff;

   always_comb begin
      for (int i = 0; i < jse_pkg::DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      adj_flat = adj;
      bcd_in   = {adj_flat[BCD_W-2:0], bin_ff[jse_pkg::BIN_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= jse_pkg::STEP_W'(jse_pkg::BIN_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - jse_pkg::STEP_W'(1);
         if (cnt_ff == jse_pkg::STEP_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= bin;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         bin_ff <= {bin_ff[jse_pkg::BIN_W-2:0], 1'b0};
         bcd_ff <= bcd_in;
      end
   end

   assign busy   = busy_ff;
   assign digits = bcd_ff;

endmodule

// ===== hdl/jse_dp.sv =====
// ----------------------------------------------------------------------------
// jse_dp
// Datapath: request latch, nesting stack, string flag, decimal converter,
// byte select and the result register.
// ----------------------------------------------------------------------------
`include "json_structure_emitter_core_macros.svh"

module jse_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  jse_pkg::ctrl_cmd_type   cmd_i,
   output jse_pkg::dp_status_type  status_o,
   input  logic [2:0]              req_command,
   input  logic [15:0]             req_count,
   input  logic signed [31:0]      req_value,
   input  logic [7:0]              req_str_byte,
   input  logic                    req_str_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   output logic [1:0]              rsp_error
);

   localparam int DW = jse_pkg::DEPTH_W;
   localparam int IW = jse_pkg::IDX_W;
   localparam int TW = jse_pkg::TOTAL_W;
   localparam int CW = jse_pkg::COUNT_BITS;

   logic [2:0]                       cmd_ff;
   logic [CW-1:0]                    cnt_ff;
   logic [31:0]                      value_ff;
   logic [7:0]                       str_byte_ff;
   logic                             str_last_ff;

   logic [DW-1:0]                    depth_ff;
   logic                             in_string_ff;
   logic [TW-1:0]                    pos_ff   [jse_pkg::MAX_DEPTH];
   logic [TW-1:0]                    total_ff [jse_pkg::MAX_DEPTH];
   logic                             obj_ff   [jse_pkg::MAX_DEPTH];

   logic [jse_pkg::DIG_W-1:0]        dig_idx_ff;
   logic                             started_ff;

   logic                             out_valid_ff;
   logic [7:0]                       out_byte_ff;
   logic                             out_last_ff;
   logic [1:0]                       out_error_ff;

   logic [IW-1:0]                    top_idx;
   logic [IW-1:0]                    push_idx;
   logic [TW-1:0]                    top_pos;
   logic [TW-1:0]                    pos_inc;
   logic                             top_obj;
   logic                             top_more;
   logic [31:0]                      mag;
   logic                             conv_busy;
   logic [jse_pkg::DIGITS-1:0][3:0]  digits;
   logic [3:0]                       cur_digit;
   logic [7:0]                       byte_in;
   logic [1:0]                       error_in;
   logic                             out_free;

   assign top_idx   = IW'(depth_ff - DW'(1));
   assign push_idx  = IW'(depth_ff);
   assign top_pos   = pos_ff[top_idx];
   assign top_obj   = obj_ff[top_idx];
   assign pos_inc   = top_pos + TW'(1);
   assign top_more  = pos_inc < total_ff[top_idx];
   assign mag       = value_ff[31] ? (~value_ff + 32'd1) : value_ff;
   assign cur_digit = digits[dig_idx_ff];
   assign out_free  = !out_valid_ff || rsp_ready;

   jse_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd_i.conv_start),
      .bin    (mag),
      .busy   (conv_busy),
      .digits (digits)
   );

   always_comb begin
      error_in = jse_pkg::ERR_NONE;
      case (cmd_i.sel)
         jse_pkg::SEL_OPEN:
            byte_in = cmd_ff[0] ? jse_pkg::CH_LBRACE : jse_pkg::CH_LBRACKET;
         jse_pkg::SEL_CLOSE:
            byte_in = top_obj ? jse_pkg::CH_RBRACE : jse_pkg::CH_RBRACKET;
         jse_pkg::SEL_SEP:
            byte_in = (top_obj && pos_inc[0]) ? jse_pkg::CH_COLON : jse_pkg::CH_COMMA;
         jse_pkg::SEL_QUOTE: byte_in = jse_pkg::CH_QUOTE;
         jse_pkg::SEL_MINUS: byte_in = jse_pkg::CH_MINUS;
         jse_pkg::SEL_DIGIT: byte_in = jse_pkg::CH_ZERO + {4'd0, cur_digit};
         jse_pkg::SEL_STR:   byte_in = str_byte_ff;
         jse_pkg::SEL_ERR_LAYER: begin
            byte_in  = jse_pkg::CH_NUL;
            error_in = jse_pkg::ERR_NO_LAYER;
         end
         jse_pkg::SEL_ERR_DEEP: begin
            byte_in  = jse_pkg::CH_NUL;
            error_in = jse_pkg::ERR_TOO_DEEP;
         end
         default: byte_in = jse_pkg::CH_NUL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_i.latch) begin
         cmd_ff      <= req_command;
         cnt_ff      <= req_count[CW-1:0];
         value_ff    <= $unsigned(req_value);
         str_byte_ff <= req_str_byte;
         str_last_ff <= req_str_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         in_string_ff <= 1'b0;
      end else begin
         if (cmd_i.latch && req_command != jse_pkg::CMD_STR_BYTE) begin
            in_string_ff <= 1'b0;
         end else if (cmd_i.set_instr) begin
            in_string_ff <= 1'b1;
         end else if (cmd_i.clr_instr) begin
            in_string_ff <= 1'b0;
         end
         if (cmd_i.push) begin
            depth_ff <= depth_ff + DW'(1);
         end else if (cmd_i.after_step && !top_more) begin
            depth_ff <= depth_ff - DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.push) begin
         pos_ff[push_idx]   <= '0;
         obj_ff[push_idx]   <= cmd_ff[0];
         total_ff[push_idx] <= cmd_ff[0] ? {cnt_ff, 1'b0} : {1'b0, cnt_ff};
      end else if (cmd_i.after_step && top_more) begin
         pos_ff[top_idx] <= pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (cmd_i.conv_start) begin
         started_ff <= 1'b0;
      end else if (cmd_i.emit && cmd_i.sel == jse_pkg::SEL_DIGIT) begin
         started_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.conv_start) begin
         dig_idx_ff <= jse_pkg::DIG_W'(jse_pkg::DIGITS - 1);
      end else if (cmd_i.dig_next) begin
         dig_idx_ff <= dig_idx_ff - jse_pkg::DIG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd_i.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.emit) begin
         out_byte_ff  <= byte_in;
         out_last_ff  <= cmd_i.last;
         out_error_ff <= error_in;
      end
   end

   always_comb begin
      status_o.cmd        = cmd_ff;
      status_o.cnt_zero   = (cnt_ff == '0);
      status_o.str_last   = str_last_ff;
      status_o.depth_zero = (depth_ff == '0);
      status_o.depth_one  = (depth_ff == DW'(1));
      status_o.depth_full = (depth_ff == DW'(jse_pkg::MAX_DEPTH));
      status_o.in_string  = in_string_ff;
      status_o.neg        = value_ff[31];
      status_o.conv_busy  = conv_busy;
      status_o.top_more   = top_more;
      status_o.dig_zero   = (cur_digit == 4'd0);
      status_o.dig_last   = (dig_idx_ff == '0);
      status_o.started    = started_ff;
      status_o.out_free   = out_free;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;
   assign rsp_error    = out_error_ff;

   `JSE_CHECK_NOW(a_depth_bound, 1'b1, depth_ff <= DW'(jse_pkg::MAX_DEPTH), "depth past limit")
   `JSE_CHECK_NOW(a_push_room, cmd_i.push, depth_ff != DW'(jse_pkg::MAX_DEPTH), "push on full stack")

endmodule

// ===== hdl/jse_ctrl.sv =====
// ----------------------------------------------------------------------------
// jse_ctrl
// Sequencer: decodes a latched request and steps the datapath through the
// bytes it produces, one byte per free output slot.
// ----------------------------------------------------------------------------
`include "json_structure_emitter_core_macros.svh"

module jse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  jse_pkg::dp_status_type  status_i,
   output jse_pkg::ctrl_cmd_type   cmd_o
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_BYTE     = 7'b0000100,
      ST_QUOTE    = 7'b0001000,
      ST_CONV     = 7'b0010000,
      ST_DIGIT    = 7'b0100000,
      ST_AFTER    = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd_o     = '0;
      cmd_o.sel = jse_pkg::SEL_OPEN;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.latch = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status_i.cmd)
               jse_pkg::CMD_OPEN_ARRAY, jse_pkg::CMD_OPEN_OBJECT: begin
                  if (status_i.out_free) begin
                     cmd_o.emit = 1'b1;
                     if (status_i.depth_full) begin
                        cmd_o.sel  = jse_pkg::SEL_ERR_DEEP;
                        cmd_o.last = 1'b1;
                        state_in   = ST_IDLE;
                     end else begin
                        cmd_o.sel  = jse_pkg::SEL_OPEN;
                        cmd_o.push = 1'b1;
                        if (status_i.cnt_zero) begin
                           state_in = ST_AFTER;
                        end else begin
                           cmd_o.last = 1'b1;
                           state_in   = ST_IDLE;
                        end
                     end
                  end
               end
               jse_pkg::CMD_INTEGER: begin
                  if (status_i.depth_zero) begin
                     if (status_i.out_free) begin
                        cmd_o.emit = 1'b1;
                        cmd_o.sel  = jse_pkg::SEL_ERR_LAYER;
                        cmd_o.last = 1'b1;
                        state_in   = ST_IDLE;
                     end
                  end else if (!status_i.neg) begin
                     cmd_o.conv_start = 1'b1;
                     state_in         = ST_CONV;
                  end else if (status_i.out_free) begin
                     cmd_o.emit       = 1'b1;
                     cmd_o.sel        = jse_pkg::SEL_MINUS;
                     cmd_o.conv_start = 1'b1;
                     state_in         = ST_CONV;
                  end
               end
               jse_pkg::CMD_STR_BYTE: begin
                  if (status_i.out_free) begin
                     cmd_o.emit = 1'b1;
                     if (!status_i.in_string) begin
                        cmd_o.sel       = jse_pkg::SEL_QUOTE;
                        cmd_o.set_instr = 1'b1;
                        state_in        = ST_BYTE;
                     end else begin
                        cmd_o.sel = jse_pkg::SEL_STR;
                        if (status_i.str_last) begin
                           state_in = ST_QUOTE;
                        end else begin
                           cmd_o.last = 1'b1;
                           state_in   = ST_IDLE;
                        end
                     end
                  end
               end
               jse_pkg::CMD_EMPTY_STR: begin
                  if (status_i.out_free) begin
                     cmd_o.emit = 1'b1;
                     cmd_o.sel  = jse_pkg::SEL_QUOTE;
                     state_in   = ST_QUOTE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_BYTE: begin
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.sel  = jse_pkg::SEL_STR;
               if (status_i.str_last) begin
                  state_in = ST_QUOTE;
               end else begin
                  cmd_o.last = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_QUOTE: begin
            if (status_i.out_free) begin
               cmd_o.emit      = 1'b1;
               cmd_o.sel       = jse_pkg::SEL_QUOTE;
               cmd_o.clr_instr = 1'b1;
               if (status_i.depth_zero) begin
                  cmd_o.last = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_AFTER;
               end
            end
         end
         ST_CONV: begin
            if (!status_i.conv_busy) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (!status_i.dig_last && !status_i.started && status_i.dig_zero) begin
               cmd_o.dig_next = 1'b1;
            end else if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.sel  = jse_pkg::SEL_DIGIT;
               if (status_i.dig_last) begin
                  state_in = ST_AFTER;
               end else begin
                  cmd_o.dig_next = 1'b1;
               end
            end
         end
         ST_AFTER: begin
            if (status_i.out_free) begin
               cmd_o.emit       = 1'b1;
               cmd_o.after_step = 1'b1;
               if (status_i.top_more) begin
                  cmd_o.sel  = jse_pkg::SEL_SEP;
                  cmd_o.last = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd_o.sel = jse_pkg::SEL_CLOSE;
                  if (status_i.depth_one) begin
                     cmd_o.last = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `JSE_CHECK_NOW(a_emit_slot, cmd_o.emit, status_i.out_free, "emit into busy output")
   `JSE_CHECK_NEXT(a_last_idle, cmd_o.emit && cmd_o.last, state_ff == ST_IDLE, "last without idle")
   `JSE_CHECK_NOW(a_after_depth, state_ff == ST_AFTER, !status_i.depth_zero, "close step at top")
   `JSE_CHECK_NOW(a_digit_ready, state_ff == ST_DIGIT, !status_i.conv_busy, "digit while converting")

endmodule

// ===== hdl/json_structure_emitter_core.sv =====
// ----------------------------------------------------------------------------
// json_structure_emitter_core
// Turns token requests into JSON text, one byte per result, with a nesting
// stack of MAX_DEPTH layers that inserts ':' / ',' and closing brackets.
// ----------------------------------------------------------------------------
// One request is processed at a time: req_ready is high only while the
// sequencer is idle, so a new request is taken once the last byte of the
// previous one is in the output register. A request is latched while idle;
// the decode state then emits the first byte (a positive integer starts the
// converter instead), and each further byte, once the output slot is free.
// An integer emits '-' in its decode state when negative, then runs the
// shift-and-add-3 binary-to-decimal converter (one input bit per cycle),
// then ten steps that each skip a leading zero or emit a digit, then one
// separator or closing bracket per step until a separator or the top layer.
// Commands 5 to 7 produce nothing.
// ----------------------------------------------------------------------------
module json_structure_emitter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [15:0]        req_count,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_str_byte,
   input  logic               req_str_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic [1:0]         rsp_error
);

   jse_pkg::ctrl_cmd_type  ctrl_cmd;
   jse_pkg::dp_status_type dp_status;

   jse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status_i  (dp_status),
      .cmd_o     (ctrl_cmd)
   );

   jse_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (ctrl_cmd),
      .status_o     (dp_status),
      .req_command  (req_command),
      .req_count    (req_count),
      .req_value    (req_value),
      .req_str_byte (req_str_byte),
      .req_str_last (req_str_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_error    (rsp_error)
   );

endmodule
